[src/kt_pkg.sv]
// shared types, codes and widths for the keyed table with top-two select
`default_nettype none

package kt_pkg;

    localparam int DEPTH_DEF  = 128;
    localparam int CMD_W      = 3;
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 8;
    localparam int ST_W       = 3;
    localparam int IDX_W      = 7;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_PAD_W  = OUT_DATA_W - (IDX_W + KEY_W + VAL_W);

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MIN    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MAX    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_MIN2   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_MAX2   = 3'd6;

    // status codes
    localparam logic [ST_W-1:0] STAT_OK      = 3'd0;
    localparam logic [ST_W-1:0] STAT_FULL    = 3'd1;
    localparam logic [ST_W-1:0] STAT_DUP     = 3'd2;
    localparam logic [ST_W-1:0] STAT_MISSING = 3'd3;
    localparam logic [ST_W-1:0] STAT_FEW     = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } kt_state_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } kt_req_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] index;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } kt_res_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } kt_ent_t;

endpackage

`default_nettype wire

[src/kt_mem.sv]
// record memory: one write port, one read port with registered data
`default_nettype none

module kt_mem #(
    parameter int DEPTH = kt_pkg::DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire kt_pkg::kt_ent_t            wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output      kt_pkg::kt_ent_t            rd_data
);

    kt_pkg::kt_ent_t ram_reg [DEPTH];
    kt_pkg::kt_ent_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= ram_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[src/kt_core.sv]
// command sequencer: search, shift and min/max scans over the record memory
`default_nettype none

module kt_core #(
    parameter int DEPTH = kt_pkg::DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_vld,
    input  wire kt_pkg::kt_req_t            req,
    output      logic                       req_rdy,
    output      logic                       res_vld,
    output      kt_pkg::kt_res_t            res,
    input  wire logic                       res_rdy,
    output      logic [$clog2(DEPTH)-1:0]   rd_addr,
    input  wire kt_pkg::kt_ent_t            rd_data,
    output      logic                       wr_en,
    output      logic [$clog2(DEPTH)-1:0]   wr_addr,
    output      kt_pkg::kt_ent_t            wr_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = kt_pkg::IDX_W;

    kt_pkg::kt_state_t state_reg, state_next;
    kt_pkg::kt_req_t   req_reg, req_next;
    kt_pkg::kt_res_t   res_reg, res_next;
    kt_pkg::kt_ent_t   best_reg, best_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     iss_reg, iss_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pidx_reg, pidx_next;
    logic              pass2_reg, pass2_next;
    logic [AW-1:0]     first_reg, first_next;
    logic              best_vld_reg, best_vld_next;
    logic [AW-1:0]     best_idx_reg, best_idx_next;

    logic locate_mode, want_max, second, hit, can_iss, scan_end, skip, better, take;
    logic new_locate, new_second, new_query, is_full;
    logic [kt_pkg::ST_W-1:0] imm_status;

    // decode of the held command
    assign locate_mode = (req_reg.cmd == kt_pkg::CMD_INSERT) ||
                         (req_reg.cmd == kt_pkg::CMD_UPDATE) ||
                         (req_reg.cmd == kt_pkg::CMD_DELETE);
    assign want_max    = (req_reg.cmd == kt_pkg::CMD_MAX) || (req_reg.cmd == kt_pkg::CMD_MAX2);
    assign second      = (req_reg.cmd == kt_pkg::CMD_MIN2) || (req_reg.cmd == kt_pkg::CMD_MAX2);

    // scan pipeline status
    assign can_iss  = iss_reg < cnt_reg;
    assign scan_end = !pend_reg && !can_iss;
    assign hit      = pend_reg && locate_mode && (rd_data.key == req_reg.key);
    assign skip     = pass2_reg && (pidx_reg == first_reg);
    assign better   = !best_vld_reg ||
                      (want_max ? (rd_data.value > best_reg.value)
                                : (rd_data.value < best_reg.value));
    assign take     = pend_reg && !locate_mode && !skip && better;

    // decode of the incoming command
    assign is_full    = cnt_reg == CW'(DEPTH);
    assign new_locate = (req.cmd == kt_pkg::CMD_INSERT && !is_full) ||
                        (req.cmd == kt_pkg::CMD_UPDATE) ||
                        (req.cmd == kt_pkg::CMD_DELETE);
    assign new_second = (req.cmd == kt_pkg::CMD_MIN2) || (req.cmd == kt_pkg::CMD_MAX2);
    assign new_query  = ((req.cmd == kt_pkg::CMD_MIN) || (req.cmd == kt_pkg::CMD_MAX)) &&
                        (cnt_reg != '0);

    always_comb
    begin
        imm_status = kt_pkg::STAT_OK;
        if (req.cmd == kt_pkg::CMD_INSERT && is_full)
        begin
            imm_status = kt_pkg::STAT_FULL;
        end
        else if (((req.cmd == kt_pkg::CMD_MIN) || (req.cmd == kt_pkg::CMD_MAX)) &&
                 (cnt_reg == '0))
        begin
            imm_status = kt_pkg::STAT_FEW;
        end
        else if (new_second && (cnt_reg < CW'(2)))
        begin
            imm_status = kt_pkg::STAT_FEW;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kt_pkg::S_IDLE:
            begin
                if (req_vld)
                begin
                    if (new_locate || new_query || (new_second && !(cnt_reg < CW'(2))))
                    begin
                        state_next = kt_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = kt_pkg::S_DONE;
                    end
                end
            end
            kt_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    state_next = (req_reg.cmd == kt_pkg::CMD_DELETE) ? kt_pkg::S_SHIFT
                                                                     : kt_pkg::S_DONE;
                end
                else if (scan_end && !(!locate_mode && second && !pass2_reg))
                begin
                    state_next = kt_pkg::S_DONE;
                end
            end
            kt_pkg::S_SHIFT:
            begin
                if (scan_end)
                begin
                    state_next = kt_pkg::S_DONE;
                end
            end
            kt_pkg::S_DONE:
            begin
                if (res_rdy)
                begin
                    state_next = kt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kt_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        req_next      = req_reg;
        res_next      = res_reg;
        best_next     = best_reg;
        cnt_next      = cnt_reg;
        iss_next      = iss_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        pass2_next    = pass2_reg;
        first_next    = first_reg;
        best_vld_next = best_vld_reg;
        best_idx_next = best_idx_reg;
        rd_addr       = iss_reg[AW-1:0];
        wr_en         = 1'b0;
        wr_addr       = pidx_reg;
        wr_data.key   = req_reg.key;
        wr_data.value = req_reg.value;

        unique case (state_reg)
            kt_pkg::S_IDLE:
            begin
                if (req_vld)
                begin
                    req_next        = req;
                    iss_next        = '0;
                    pend_next       = 1'b0;
                    pass2_next      = 1'b0;
                    best_vld_next   = 1'b0;
                    res_next        = '0;
                    res_next.status = imm_status;
                end
            end
            kt_pkg::S_SCAN:
            begin
                // keep one read in flight per cycle
                if (can_iss && !hit)
                begin
                    pend_next = 1'b1;
                    pidx_next = iss_reg[AW-1:0];
                    iss_next  = iss_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (take)
                begin
                    best_vld_next = 1'b1;
                    best_idx_next = pidx_reg;
                    best_next     = rd_data;
                end

                if (hit)
                begin
                    res_next.status = (req_reg.cmd == kt_pkg::CMD_INSERT) ? kt_pkg::STAT_DUP
                                                                          : kt_pkg::STAT_OK;
                    res_next.index  = IW'(pidx_reg);
                    res_next.key    = rd_data.key;
                    res_next.value  = rd_data.value;
                    if (req_reg.cmd == kt_pkg::CMD_UPDATE)
                    begin
                        wr_en = 1'b1;
                    end
                    // shift starts with the entry just above the hit
                    iss_next = CW'(pidx_reg) + CW'(1);
                end
                else if (scan_end)
                begin
                    if (locate_mode)
                    begin
                        if (req_reg.cmd == kt_pkg::CMD_INSERT)
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = cnt_reg[AW-1:0];
                            cnt_next        = cnt_reg + CW'(1);
                            res_next.status = kt_pkg::STAT_OK;
                            res_next.index  = IW'(cnt_reg);
                            res_next.key    = req_reg.key;
                            res_next.value  = req_reg.value;
                        end
                        else
                        begin
                            res_next        = '0;
                            res_next.status = kt_pkg::STAT_MISSING;
                        end
                    end
                    else if (second && !pass2_reg)
                    begin
                        // rescan without the first pick
                        pass2_next    = 1'b1;
                        first_next    = best_idx_reg;
                        iss_next      = '0;
                        best_vld_next = 1'b0;
                    end
                    else
                    begin
                        res_next.status = kt_pkg::STAT_OK;
                        res_next.index  = IW'(best_idx_reg);
                        res_next.key    = best_reg.key;
                        res_next.value  = best_reg.value;
                    end
                end
            end
            kt_pkg::S_SHIFT:
            begin
                if (can_iss)
                begin
                    pend_next = 1'b1;
                    pidx_next = iss_reg[AW-1:0];
                    iss_next  = iss_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                // entry read last cycle moves down one place
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pidx_reg - AW'(1);
                    wr_data = rd_data;
                end
                if (scan_end)
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            kt_pkg::S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= kt_pkg::S_IDLE;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            pass2_reg    <= 1'b0;
            best_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            pass2_reg    <= pass2_next;
            best_vld_reg <= best_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        best_reg     <= best_next;
        iss_reg      <= iss_next;
        pidx_reg     <= pidx_next;
        first_reg    <= first_next;
        best_idx_reg <= best_idx_next;
    end

    assign req_rdy = state_reg == kt_pkg::S_IDLE;
    assign res_vld = state_reg == kt_pkg::S_DONE;
    assign res     = res_reg;

endmodule

`default_nettype wire

[src/keyed_table_with_top_two_select_top.sv]
// top level of the keyed table: stream ports, core, record memory, output register
// items answered without a search (full table, too few entries, unused command) skip the scan;
//   a search walks the records at one read per cycle, delete adds a shift of the later
//   records, second min/max does two passes
// the core works on one item at a time; the memory read port (one entry a cycle) sets its pace
// reset: entry count cleared at once, record memory keeps its contents, no clearing pass
`default_nettype none

module keyed_table_with_top_two_select_top #(
    parameter int DEPTH = kt_pkg::DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    input  wire logic [kt_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // key, value
    input  wire logic [kt_pkg::CMD_W-1:0]        s_axis_tuser,   // cmd
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output      logic [kt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // index, found_key, found_value, pad
    output      logic [kt_pkg::ST_W-1:0]         m_axis_tuser    // status
);

    localparam int AW = $clog2(DEPTH);

    kt_pkg::kt_req_t req;
    kt_pkg::kt_res_t core_res;
    kt_pkg::kt_res_t out_res_reg, out_res_next;
    logic            out_vld_reg, out_vld_next;
    logic            core_res_vld, res_rdy;

    logic [AW-1:0]   rd_addr, wr_addr;
    logic            wr_en;
    kt_pkg::kt_ent_t rd_data, wr_data;

    // unpack the input item
    assign req.cmd   = s_axis_tuser;
    assign req.key   = s_axis_tdata[kt_pkg::KEY_W-1:0];
    assign req.value = s_axis_tdata[kt_pkg::KEY_W +: kt_pkg::VAL_W];

    kt_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_vld (s_axis_tvalid),
        .req     (req),
        .req_rdy (s_axis_tready),
        .res_vld (core_res_vld),
        .res     (core_res),
        .res_rdy (res_rdy),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    kt_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register: the slot frees when the held item is taken
    assign res_rdy = !out_vld_reg || m_axis_tready;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        out_res_next = out_res_reg;
        if (out_vld_reg && m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
        if (core_res_vld && res_rdy)
        begin
            out_vld_next = 1'b1;
            out_res_next = core_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    // pack the result item
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tdata  = {{kt_pkg::OUT_PAD_W{1'b0}}, out_res_reg.value,
                            out_res_reg.key, out_res_reg.index};

`ifndef SYNTH
    // the core takes no new item while a result is still waiting inside it
    assert property (@(posedge clk) disable iff (!rst_n)
        core_res_vld |-> !s_axis_tready)
    else $error("input accepted while core holds a result");

    // the core is not ready again in the cycle right after it accepts an item
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("core ready right after accepting an item");

    // a result handed over by the core lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (core_res_vld && res_rdy) |=> m_axis_tvalid)
    else $error("result from core lost");
`endif

endmodule

`default_nettype wire

[tb/kt_table_check.sv]
// checker for the keyed table: mirrors the record table and compares every result item
`timescale 1ns / 1ps

module kt_table_check #(
    parameter int DEPTH = kt_pkg::DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic [kt_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // key, value
    input  wire logic [kt_pkg::CMD_W-1:0]      s_axis_tuser,   // cmd
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [kt_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // index, found_key, found_value, pad
    input  wire logic [kt_pkg::ST_W-1:0]       m_axis_tuser,   // status
    output int                                 errors,
    output int                                 pending,
    output int                                 results_seen,
    output int                                 peak_fill,
    output int                                 n_ok,
    output int                                 n_full,
    output int                                 n_dup,
    output int                                 n_missing,
    output int                                 n_few
);

    localparam int MAX_SHOWN = 10;

    // mirrored record table
    logic [kt_pkg::KEY_W-1:0] rec_key [DEPTH];
    logic [kt_pkg::VAL_W-1:0] rec_val [DEPTH];
    int                       rec_fill = 0;

    kt_pkg::kt_res_t awaited_results [$];

    int fail_count = 0;
    int seen_count = 0;
    int fill_max   = 0;
    int cnt_ok     = 0;
    int cnt_full   = 0;
    int cnt_dup    = 0;
    int cnt_miss   = 0;
    int cnt_few    = 0;

    function automatic int find_key(input logic [kt_pkg::KEY_W-1:0] k);
        for (int i = 0; i < rec_fill; i++)
            if (rec_key[i] == k)
                return i;
        return -1;
    endfunction

    // lowest-index extreme value, leaving out position skip
    function automatic int pick_extreme(input bit want_max, input int skip);
        int best;
        best = -1;
        for (int i = 0; i < rec_fill; i++)
        begin
            if (i == skip)
                continue;
            if (best < 0)
                best = i;
            else if (want_max ? (rec_val[i] > rec_val[best]) : (rec_val[i] < rec_val[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic kt_pkg::kt_res_t record_result(input int pos);
        kt_pkg::kt_res_t r;
        r.status = kt_pkg::STAT_OK;
        r.index  = pos[kt_pkg::IDX_W-1:0];
        r.key    = rec_key[pos];
        r.value  = rec_val[pos];
        return r;
    endfunction

    // applies one command to the mirrored table and returns its result item
    function automatic kt_pkg::kt_res_t table_apply(input kt_pkg::kt_req_t rq);
        kt_pkg::kt_res_t r;
        int              pos;
        int              first;
        r = '0;
        case (rq.cmd)
            kt_pkg::CMD_INSERT:
            begin
                pos = find_key(rq.key);
                if (rec_fill >= DEPTH)
                    r.status = kt_pkg::STAT_FULL;
                else if (pos >= 0)
                begin
                    r = record_result(pos);
                    r.status = kt_pkg::STAT_DUP;
                end
                else
                begin
                    rec_key[rec_fill] = rq.key;
                    rec_val[rec_fill] = rq.value;
                    r = record_result(rec_fill);
                    rec_fill++;
                end
            end
            kt_pkg::CMD_UPDATE:
            begin
                pos = find_key(rq.key);
                if (pos < 0)
                    r.status = kt_pkg::STAT_MISSING;
                else
                begin
                    r = record_result(pos);
                    rec_val[pos] = rq.value;
                end
            end
            kt_pkg::CMD_DELETE:
            begin
                pos = find_key(rq.key);
                if (pos < 0)
                    r.status = kt_pkg::STAT_MISSING;
                else
                begin
                    r = record_result(pos);
                    for (int i = pos; i + 1 < rec_fill; i++)
                    begin
                        rec_key[i] = rec_key[i+1];
                        rec_val[i] = rec_val[i+1];
                    end
                    rec_fill--;
                end
            end
            kt_pkg::CMD_MIN, kt_pkg::CMD_MAX:
            begin
                if (rec_fill < 1)
                    r.status = kt_pkg::STAT_FEW;
                else
                    r = record_result(pick_extreme(rq.cmd == kt_pkg::CMD_MAX, -1));
            end
            kt_pkg::CMD_MIN2, kt_pkg::CMD_MAX2:
            begin
                if (rec_fill < 2)
                    r.status = kt_pkg::STAT_FEW;
                else
                begin
                    first = pick_extreme(rq.cmd == kt_pkg::CMD_MAX2, -1);
                    r = record_result(pick_extreme(rq.cmd == kt_pkg::CMD_MAX2, first));
                end
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
            $display("%t mismatch: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin
        kt_pkg::kt_res_t want;
        kt_pkg::kt_res_t seen;
        kt_pkg::kt_req_t req;
        if (rst_n)
        begin
            // result side first: a result never belongs to an item taken at the same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_count++;
                seen.status = m_axis_tuser;
                seen.index  = m_axis_tdata[kt_pkg::IDX_W-1:0];
                seen.key    = m_axis_tdata[kt_pkg::IDX_W +: kt_pkg::KEY_W];
                seen.value  = m_axis_tdata[kt_pkg::IDX_W+kt_pkg::KEY_W +: kt_pkg::VAL_W];
                if (awaited_results.size() == 0)
                    note_failure($sformatf({"result %0d with nothing awaited:",
                        " status %0d index %0d key %h value %h"},
                        seen_count, seen.status, seen.index, seen.key, seen.value));
                else
                begin
                    want = awaited_results.pop_front();
                    if (seen.status !== want.status || seen.index !== want.index ||
                        seen.key !== want.key || seen.value !== want.value)
                        note_failure($sformatf({"result %0d: expected status %0d index %0d",
                            " key %h value %h, got status %0d index %0d key %h value %h"},
                            seen_count,
                            want.status, want.index, want.key, want.value,
                            seen.status, seen.index, seen.key, seen.value));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                req.cmd   = s_axis_tuser;
                req.key   = s_axis_tdata[kt_pkg::KEY_W-1:0];
                req.value = s_axis_tdata[kt_pkg::KEY_W +: kt_pkg::VAL_W];
                want = table_apply(req);
                awaited_results.push_back(want);
                if (rec_fill > fill_max)
                    fill_max = rec_fill;
                case (want.status)
                    kt_pkg::STAT_OK:      cnt_ok++;
                    kt_pkg::STAT_FULL:    cnt_full++;
                    kt_pkg::STAT_DUP:     cnt_dup++;
                    kt_pkg::STAT_MISSING: cnt_miss++;
                    kt_pkg::STAT_FEW:     cnt_few++;
                    default:              ;
                endcase
            end
        end

        errors       <= fail_count;
        pending      <= awaited_results.size();
        results_seen <= seen_count;
        peak_fill    <= fill_max;
        n_ok         <= cnt_ok;
        n_full       <= cnt_full;
        n_dup        <= cnt_dup;
        n_missing    <= cnt_miss;
        n_few        <= cnt_few;
    end

endmodule

[tb/tb.sv]
// testbench top for the keyed table: stimulus, idling phases, watchdog and verdict
`timescale 1ns / 1ps

module tb;

    // the unused command code, ignored by the block
    localparam logic [kt_pkg::CMD_W-1:0] CMD_NONE = 3'd7;

    localparam int WATCHDOG_LIMIT = 4000;   // worst item is a second min/max, two passes over the table, plus stalls
    localparam int HOLD_CYCLES    = 400;    // long receiver hold-off
    localparam int DRAIN_CYCLES   = 300;    // quiet time after the last result
    localparam int POOL_SIZE      = 192;
    localparam int WINDOW         = 40;     // keys used by the random mix, keeps hits frequent
    localparam int FILL_KEYS      = 140;    // more than DEPTH distinct keys, so the table fills

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [kt_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;     // key, value
    logic [kt_pkg::CMD_W-1:0]      s_axis_tuser  = '0;     // cmd
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [kt_pkg::OUT_DATA_W-1:0] m_axis_tdata;           // index, found_key, found_value, pad
    logic [kt_pkg::ST_W-1:0]       m_axis_tuser;           // status

    int errors;
    int pending;
    int results_seen;
    int peak_fill;
    int n_ok;
    int n_full;
    int n_dup;
    int n_missing;
    int n_few;

    // idling knobs, percent of cycles
    int  idle_pct  = 0;
    int  stall_pct = 0;
    bit  hold_go   = 1'b0;
    bit  hold_off  = 1'b0;
    int  items_sent = 0;

    logic [kt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    keyed_table_with_top_two_select_top #(
        .DEPTH (kt_pkg::DEPTH_DEF)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    kt_table_check #(
        .DEPTH (kt_pkg::DEPTH_DEF)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .errors        (errors),
        .pending       (pending),
        .results_seen  (results_seen),
        .peak_fill     (peak_fill),
        .n_ok          (n_ok),
        .n_full        (n_full),
        .n_dup         (n_dup),
        .n_missing     (n_missing),
        .n_few         (n_few)
    );

    // receiver: random stalls at the falling edge, forced low during the hold-off
    always @(negedge clk)
        m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);

    // long hold-off, counted here so the sender keeps offering and the block backs up
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // watchdog: ends the run when no item moves on either side for too long
    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stuck = 0;
            else
                stuck++;
        end
        $display("watchdog: no item moved for %0d cycles, %0d results still awaited",
                 WATCHDOG_LIMIT, pending);
        $display("tb failed");
        $finish;
    end

    // offers one item, entered and left at a falling edge; valid stays high into the next item
    task automatic offer(input logic [kt_pkg::CMD_W-1:0] c, input logic [kt_pkg::KEY_W-1:0] k,
                         input logic [kt_pkg::VAL_W-1:0] v);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c;
        s_axis_tdata  <= {v, k};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // values lean toward the extremes and a few small numbers so ties are common
    function automatic logic [kt_pkg::VAL_W-1:0] value_pick();
        int r;
        r = $urandom_range(0, 7);
        case (r)
            0:       return '0;
            1:       return '1;
            2:       return kt_pkg::VAL_W'($urandom_range(0, 3));
            default: return kt_pkg::VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [kt_pkg::CMD_W-1:0] query_pick();
        case ($urandom_range(0, 3))
            0:       return kt_pkg::CMD_MIN;
            1:       return kt_pkg::CMD_MAX;
            2:       return kt_pkg::CMD_MIN2;
            default: return kt_pkg::CMD_MAX2;
        endcase
    endfunction

    task automatic random_item();
        int                       r;
        logic [kt_pkg::CMD_W-1:0] c;
        logic [kt_pkg::KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 30)
            c = kt_pkg::CMD_INSERT;
        else if (r < 45)
            c = kt_pkg::CMD_UPDATE;
        else if (r < 60)
            c = kt_pkg::CMD_DELETE;
        else if (r < 96)
            c = query_pick();
        else
            c = CMD_NONE;
        // inserts stay in the window so later deletes can empty the table again
        if (c == kt_pkg::CMD_INSERT || $urandom_range(0, 99) < 85)
            k = key_pool[$urandom_range(0, WINDOW-1)];
        else
            k = $urandom;
        offer(c, k, value_pick());
    endtask

    // fills the table past its depth, queries and updates it full, then drains it with long shifts
    task automatic fill_and_drain();
        int start;
        int j;
        for (int i = 0; i < FILL_KEYS; i++)
            offer(kt_pkg::CMD_INSERT, key_pool[i], value_pick());
        offer(kt_pkg::CMD_INSERT, key_pool[0], value_pick());          // full wins over duplicate
        offer(kt_pkg::CMD_INSERT, key_pool[FILL_KEYS], value_pick());
        for (int i = 0; i < 3; i++)
        begin
            offer(kt_pkg::CMD_MIN,  $urandom, value_pick());
            offer(kt_pkg::CMD_MAX,  $urandom, value_pick());
            offer(kt_pkg::CMD_MIN2, $urandom, value_pick());
            offer(kt_pkg::CMD_MAX2, $urandom, value_pick());
        end
        for (int i = 0; i < 8; i++)
            offer(kt_pkg::CMD_UPDATE, key_pool[$urandom_range(0, FILL_KEYS-1)], value_pick());
        start = $urandom_range(0, FILL_KEYS-1);
        for (int i = 0; i < FILL_KEYS; i++)
        begin
            j = (start + i) % FILL_KEYS;
            offer(kt_pkg::CMD_DELETE, key_pool[j], value_pick());
            if (i % 16 == 15)
                offer(query_pick(), $urandom, value_pick());
        end
    endtask

    // empty-table cases, ties, duplicate insert, update, delete with shift, unused command
    task automatic directed_items();
        offer(kt_pkg::CMD_MIN,    32'h0000_0000, 8'h00);     // too few entries
        offer(kt_pkg::CMD_MAX2,   32'hFFFF_FFFF, 8'hFF);
        offer(kt_pkg::CMD_UPDATE, 32'hFFFF_FFFF, 8'h55);     // missing key
        offer(kt_pkg::CMD_DELETE, 32'h0000_0000, 8'hAA);
        offer(CMD_NONE,           32'hFFFF_FFFF, 8'hFF);     // ignored
        offer(kt_pkg::CMD_INSERT, 32'h0000_0000, 8'h00);
        offer(kt_pkg::CMD_MIN2,   32'h0000_0000, 8'h00);     // one entry is too few for second pick
        offer(kt_pkg::CMD_MAX,    32'h0000_0000, 8'h00);
        offer(kt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 8'hFF);
        offer(kt_pkg::CMD_MIN2,   32'h0000_0000, 8'h00);
        offer(kt_pkg::CMD_INSERT, 32'h0000_0000, 8'h07);     // duplicate key
        offer(kt_pkg::CMD_INSERT, 32'h1234_5678, 8'hFF);     // ties the maximum
        offer(kt_pkg::CMD_MAX,    32'h0000_0000, 8'h00);
        offer(kt_pkg::CMD_MAX2,   32'h0000_0000, 8'h00);     // equal value at another index
        offer(kt_pkg::CMD_INSERT, 32'h8000_0001, 8'h00);     // ties the minimum
        offer(kt_pkg::CMD_MIN,    32'h0000_0000, 8'h00);
        offer(kt_pkg::CMD_MIN2,   32'h0000_0000, 8'h00);
        offer(kt_pkg::CMD_UPDATE, 32'hFFFF_FFFF, 8'h80);     // returns the old value
        offer(kt_pkg::CMD_MAX,    32'h0000_0000, 8'h00);
        offer(kt_pkg::CMD_DELETE, 32'h0000_0000, 8'h00);     // later records shift down
        offer(kt_pkg::CMD_MIN,    32'h0000_0000, 8'h00);
        offer(kt_pkg::CMD_MAX2,   32'h0000_0000, 8'h00);
        offer(CMD_NONE,           32'h0000_0000, 8'h00);
        offer(kt_pkg::CMD_DELETE, 32'h1234_5678, 8'h00);
        offer(kt_pkg::CMD_DELETE, 32'h8000_0001, 8'h00);
    endtask

    initial
    begin
        // distinct keys: the low byte carries the pool index, plus both all-zero and all-one keys
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = {(kt_pkg::KEY_W-8)'($urandom), 8'(i)};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_items();

        // no idling, with the long hold-off early on
        for (int i = 0; i < 300; i++)
        begin
            if (i == 60)
                hold_go = 1'b1;
            random_item();
        end
        fill_and_drain();

        // sender mostly idle
        idle_pct = 80;
        for (int i = 0; i < 300; i++)
            random_item();

        // receiver mostly stalling
        idle_pct  = 0;
        stall_pct = 80;
        for (int i = 0; i < 300; i++)
            random_item();

        // light idling on both sides
        idle_pct  = 10;
        stall_pct = 10;
        for (int i = 0; i < 150; i++)
            random_item();
        fill_and_drain();

        s_axis_tvalid <= 1'b0;
        stall_pct = 0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d items sent, %0d results checked, table filled up to %0d of %0d",
                 items_sent, results_seen, peak_fill, kt_pkg::DEPTH_DEF);
        $display("summary: status ok %0d, full %0d, duplicate %0d, missing key %0d, too few %0d",
                 n_ok, n_full, n_dup, n_missing, n_few);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

[sim.f]
src/kt_pkg.sv
src/kt_mem.sv
src/kt_core.sv
src/keyed_table_with_top_two_select_top.sv
tb/kt_table_check.sv
tb/tb.sv
